>>> hw/rtl/ioa_pkg.sv
// Package for the interval offset allocator: sizes, codes and state type.
// Depends on nothing; the allocator top level refers to it by scoped names.

package ioa_pkg;

    // Store depths.
    localparam int MAX_REF_RANGES  = 16;
    localparam int MAX_TEST_RANGES = 16;

    // Field widths.
    localparam int BATCH_W  = 24;
    localparam int RUN_W    = 4;
    localparam int STATUS_W = 2;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W = 1;

    // Derived widths.
    localparam int REF_IDX_W  = (MAX_REF_RANGES > 1) ? $clog2(MAX_REF_RANGES) : 1;
    localparam int TEST_IDX_W = (MAX_TEST_RANGES > 1) ? $clog2(MAX_TEST_RANGES) : 1;
    localparam int REF_CNT_W  = $clog2(MAX_REF_RANGES + 1);
    localparam int TEST_CNT_W = $clog2(MAX_TEST_RANGES + 1);
    localparam int SCAN_W     = $clog2(MAX_REF_RANGES + MAX_TEST_RANGES + 1);
    localparam int POS_W      = BATCH_W + 1;   // a shifted endpoint
    localparam int LIM_W      = BATCH_W + 2;   // offset plus twice the step

    // Register reset values.
    localparam logic [BATCH_W-1:0] STEP_RESET      = BATCH_W'(1000);
    localparam logic [BATCH_W-1:0] MAX_BATCH_RESET = BATCH_W'(9999999);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_STEP = 1'b0,
        CFG_MAX_BATCH   = 1'b1
    } t_cfg_reg;

    typedef enum logic [KIND_W-1:0] {
        KIND_REF   = 2'd0,
        KIND_TEST  = 2'd1,
        KIND_SOLVE = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_LIMIT    = 2'd2,
        ST_CAPACITY = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_T_RD,
        S_T_WAIT,
        S_CHECK,
        S_SCAN,
        S_WRITE,
        S_E_RD,
        S_E_WAIT,
        S_FAIL
    } t_state;

endpackage

>>> hw/rtl/interval_offset_allocator.sv
// Interval offset allocator top level: range stores, solve sequencer, result register.
// Depends on ioa_pkg for sizes, codes and the sequencer state type.
//
//   Channel | Direction | Handshake                    | Beat contents
//   --------+-----------+------------------------------+--------------------------------------
//   in      | input     | i_in_valid / o_in_ready      | kind, first_batch, last_batch
//   out     | output    | o_out_valid / i_out_ready    | run_index, offset, status, last
//   cfg     | input     | i_cfg_we (no back-pressure)  | register index, write data
//
// A load beat (reference or test range) is taken and written straight into its
// memory. A solve beat starts the sequencer, and the input stays closed until its
// final result has been moved into the output register. Every offset try scans the
// stored ranges one per cycle through the memory read port; each test range is
// fetched (S_T_RD, S_T_WAIT), tried (S_CHECK, S_SCAN) and written back (S_WRITE), and
// each offset result is read (S_E_RD, S_E_WAIT) before it is placed, a failure result
// from S_FAIL alone. Reset is synchronous and active low; it clears the counts and
// flags, so the memories need no clearing pass.
// A stalled output only holds the sequencer while it waits to place the next result.

module interval_offset_allocator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [ioa_pkg::KIND_W-1:0]         i_kind,
    input  logic [ioa_pkg::BATCH_W-1:0]        i_first_batch,
    input  logic [ioa_pkg::BATCH_W-1:0]        i_last_batch,

    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [ioa_pkg::RUN_W-1:0]          o_run_index,
    output logic [ioa_pkg::BATCH_W-1:0]        o_offset,
    output logic [ioa_pkg::STATUS_W-1:0]       o_status,
    output logic                               o_last,

    input  logic                               i_cfg_we,
    input  logic [ioa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ioa_pkg::BATCH_W-1:0]        i_cfg_data
);

    localparam int BW  = ioa_pkg::BATCH_W;
    localparam int PW  = ioa_pkg::POS_W;
    localparam int LW  = ioa_pkg::LIM_W;
    localparam int RIW = ioa_pkg::REF_IDX_W;
    localparam int TIW = ioa_pkg::TEST_IDX_W;
    localparam int RCW = ioa_pkg::REF_CNT_W;
    localparam int TCW = ioa_pkg::TEST_CNT_W;
    localparam int SW  = ioa_pkg::SCAN_W;

    // True when two inclusive ranges share any batch number; checked both ways.
    function automatic logic f_clash(input logic [PW-1:0] alo, input logic [PW-1:0] ahi,
                                     input logic [PW-1:0] blo, input logic [PW-1:0] bhi);
        logic c0, c1, c2, c3;
        c0 = (blo >= alo) && (blo <= ahi);
        c1 = (bhi >= alo) && (bhi <= ahi);
        c2 = (alo >= blo) && (alo <= bhi);
        c3 = (ahi >= blo) && (ahi <= bhi);
        return c0 || c1 || c2 || c3;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [BW-1:0] r_offset_step;
    logic [BW-1:0] r_max_batch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_step <= ioa_pkg::STEP_RESET;
            r_max_batch   <= ioa_pkg::MAX_BATCH_RESET;
        end else if (i_cfg_we) begin
            case (ioa_pkg::t_cfg_reg'(i_cfg_index))
                ioa_pkg::CFG_OFFSET_STEP: r_offset_step <= i_cfg_data;
                ioa_pkg::CFG_MAX_BATCH:   r_max_batch   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A zero step behaves as a step of one.
    logic [BW-1:0] eff_step;
    assign eff_step = (r_offset_step == '0) ? BW'(1) : r_offset_step;

    // ------------------------------------------------------------------
    // Memories. The reference memory holds {low, high}; the test memory holds
    // {low, high, shift}. Both have one write port and one registered read port.
    // ------------------------------------------------------------------
    logic [2*BW-1:0] ref_mem  [ioa_pkg::MAX_REF_RANGES];
    logic [3*BW-1:0] test_mem [ioa_pkg::MAX_TEST_RANGES];

    logic            ref_we,  ref_re;
    logic [RIW-1:0]  ref_wa,  ref_ra;
    logic [2*BW-1:0] ref_wd,  r_ref_q;
    logic            test_we, test_re;
    logic [TIW-1:0]  test_wa, test_ra;
    logic [3*BW-1:0] test_wd, r_test_q;

    always_ff @(posedge i_clk) begin
        if (ref_we) begin
            ref_mem[ref_wa] <= ref_wd;
        end
        if (ref_re) begin
            r_ref_q <= ref_mem[ref_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (test_we) begin
            test_mem[test_wa] <= test_wd;
        end
        if (test_re) begin
            r_test_q <= test_mem[test_ra];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer registers.
    // ------------------------------------------------------------------
    ioa_pkg::t_state  r_state, n_state;
    logic [RCW-1:0]   r_ref_count, n_ref_count;
    logic [TCW-1:0]   r_test_count, n_test_count;
    logic             r_cap, n_cap;
    logic [TCW-1:0]   r_t, n_t;             // test range being placed
    logic [TCW-1:0]   r_e, n_e;             // result being emitted
    logic [SW-1:0]    r_k, n_k;             // scan position over refs then tests
    logic             r_pv, n_pv;           // a scan read is in flight
    logic             r_pref, n_pref;       // that read came from the reference memory
    logic             r_pskip, n_pskip;     // that read is the range being placed
    logic [BW-1:0]    r_cur_lo, n_cur_lo;
    logic [BW-1:0]    r_cur_hi, n_cur_hi;
    logic [BW-1:0]    r_shift, n_shift;
    logic             r_overflow, n_overflow;
    ioa_pkg::t_status r_fail_code, n_fail_code;

    logic                         r_out_valid, n_out_valid;
    logic [ioa_pkg::RUN_W-1:0]    r_out_run, n_out_run;
    logic [BW-1:0]                r_out_offset, n_out_offset;
    ioa_pkg::t_status             r_out_status, n_out_status;
    logic                         r_out_last, n_out_last;

    // Datapath terms.
    logic           in_fire;
    logic           out_free;
    logic [SW-1:0]  scan_total;
    logic [SW-1:0]  scan_tidx;
    logic [LW-1:0]  try_end;
    logic           past_limit;
    logic [PW-1:0]  cur_lo_p, cur_hi_p;
    logic [PW-1:0]  mem_lo_p, mem_hi_p;
    logic           hit;

    assign o_in_ready = (r_state == ioa_pkg::S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    assign scan_total = SW'(r_ref_count) + SW'(r_test_count);
    assign scan_tidx  = r_k - SW'(r_ref_count);

    // The offset is still allowed while offset + 2 * step <= max_batch.
    assign try_end    = LW'(r_shift) + LW'({eff_step, 1'b0});
    assign past_limit = try_end > LW'(r_max_batch);

    assign cur_lo_p = PW'(r_cur_lo) + PW'(r_shift);
    assign cur_hi_p = PW'(r_cur_hi) + PW'(r_shift);

    always_comb begin
        if (r_pref) begin
            mem_lo_p = PW'(r_ref_q[2*BW-1:BW]);
            mem_hi_p = PW'(r_ref_q[BW-1:0]);
        end else begin
            mem_lo_p = PW'(r_test_q[3*BW-1:2*BW]) + PW'(r_test_q[BW-1:0]);
            mem_hi_p = PW'(r_test_q[2*BW-1:BW]) + PW'(r_test_q[BW-1:0]);
        end
    end

    assign hit = r_pv && !r_pskip && f_clash(mem_lo_p, mem_hi_p, cur_lo_p, cur_hi_p);

    // ------------------------------------------------------------------
    // Next state, memory control and datapath updates.
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_ref_count  = r_ref_count;
        n_test_count = r_test_count;
        n_cap        = r_cap;
        n_t          = r_t;
        n_e          = r_e;
        n_k          = r_k;
        n_pv         = r_pv;
        n_pref       = r_pref;
        n_pskip      = r_pskip;
        n_cur_lo     = r_cur_lo;
        n_cur_hi     = r_cur_hi;
        n_shift      = r_shift;
        n_overflow   = r_overflow;
        n_fail_code  = r_fail_code;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_run    = r_out_run;
        n_out_offset = r_out_offset;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;

        ref_we  = 1'b0;
        ref_wa  = r_ref_count[RIW-1:0];
        ref_wd  = {i_first_batch, i_last_batch};
        ref_re  = 1'b0;
        ref_ra  = r_k[RIW-1:0];
        test_we = 1'b0;
        test_wa = r_test_count[TIW-1:0];
        test_wd = {i_first_batch, i_last_batch, BW'(0)};
        test_re = 1'b0;
        test_ra = r_t[TIW-1:0];

        case (r_state)
            ioa_pkg::S_IDLE: begin
                if (in_fire) begin
                    case (ioa_pkg::t_kind'(i_kind))
                        ioa_pkg::KIND_REF: begin
                            if (r_ref_count < RCW'(ioa_pkg::MAX_REF_RANGES)) begin
                                ref_we      = 1'b1;
                                n_ref_count = r_ref_count + RCW'(1);
                            end else begin
                                n_cap = 1'b1;
                            end
                        end
                        ioa_pkg::KIND_TEST: begin
                            if (r_test_count < TCW'(ioa_pkg::MAX_TEST_RANGES)) begin
                                test_we      = 1'b1;
                                n_test_count = r_test_count + TCW'(1);
                            end else begin
                                n_cap = 1'b1;
                            end
                        end
                        ioa_pkg::KIND_SOLVE: begin
                            n_overflow = 1'b0;
                            n_t        = '0;
                            n_e        = '0;
                            if (r_cap) begin
                                n_fail_code = ioa_pkg::ST_CAPACITY;
                                n_state     = ioa_pkg::S_FAIL;
                            end else if (r_test_count == '0) begin
                                n_fail_code = ioa_pkg::ST_EMPTY;
                                n_state     = ioa_pkg::S_FAIL;
                            end else begin
                                n_state = ioa_pkg::S_T_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ioa_pkg::S_T_RD: begin
                test_re = 1'b1;
                n_state = ioa_pkg::S_T_WAIT;
            end

            ioa_pkg::S_T_WAIT: begin
                n_cur_lo = r_test_q[3*BW-1:2*BW];
                n_cur_hi = r_test_q[2*BW-1:BW];
                n_shift  = r_test_q[BW-1:0];
                n_state  = ioa_pkg::S_CHECK;
            end

            ioa_pkg::S_CHECK: begin
                n_k  = '0;
                n_pv = 1'b0;
                if (past_limit) begin
                    // The range keeps its last tried offset for the ranges after it.
                    n_overflow = 1'b1;
                    n_state    = ioa_pkg::S_WRITE;
                end else begin
                    n_state = ioa_pkg::S_SCAN;
                end
            end

            ioa_pkg::S_SCAN: begin
                // Issue one read per cycle and compare the entry read last cycle.
                if (r_k < scan_total) begin
                    n_pv = 1'b1;
                    n_k  = r_k + SW'(1);
                    if (r_k < SW'(r_ref_count)) begin
                        ref_re  = 1'b1;
                        n_pref  = 1'b1;
                        n_pskip = 1'b0;
                    end else begin
                        test_re = 1'b1;
                        test_ra = scan_tidx[TIW-1:0];
                        n_pref  = 1'b0;
                        n_pskip = (scan_tidx == SW'(r_t));
                    end
                end else begin
                    n_pv = 1'b0;
                end
                if (hit) begin
                    n_shift = r_shift + eff_step;
                    n_pv    = 1'b0;
                    n_state = ioa_pkg::S_CHECK;
                end else if (r_k == scan_total && !r_pv) begin
                    n_state = ioa_pkg::S_WRITE;
                end
            end

            ioa_pkg::S_WRITE: begin
                test_we = 1'b1;
                test_wa = r_t[TIW-1:0];
                test_wd = {r_cur_lo, r_cur_hi, r_shift};
                if (r_t + TCW'(1) == r_test_count) begin
                    if (r_overflow) begin
                        n_fail_code = ioa_pkg::ST_LIMIT;
                        n_state     = ioa_pkg::S_FAIL;
                    end else begin
                        n_state = ioa_pkg::S_E_RD;
                    end
                end else begin
                    n_t     = r_t + TCW'(1);
                    n_state = ioa_pkg::S_T_RD;
                end
            end

            ioa_pkg::S_E_RD: begin
                test_re = 1'b1;
                test_ra = r_e[TIW-1:0];
                n_state = ioa_pkg::S_E_WAIT;
            end

            ioa_pkg::S_E_WAIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_run    = ioa_pkg::RUN_W'(r_e);
                    n_out_offset = r_test_q[BW-1:0];
                    n_out_status = ioa_pkg::ST_OK;
                    n_out_last   = (r_e + TCW'(1) == r_test_count);
                    if (r_e + TCW'(1) == r_test_count) begin
                        n_ref_count  = '0;
                        n_test_count = '0;
                        n_cap        = 1'b0;
                        n_state      = ioa_pkg::S_IDLE;
                    end else begin
                        n_e     = r_e + TCW'(1);
                        n_state = ioa_pkg::S_E_RD;
                    end
                end
            end

            ioa_pkg::S_FAIL: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_run    = '0;
                    n_out_offset = '0;
                    n_out_status = r_fail_code;
                    n_out_last   = 1'b1;
                    n_ref_count  = '0;
                    n_test_count = '0;
                    n_cap        = 1'b0;
                    n_state      = ioa_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = ioa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ioa_pkg::S_IDLE;
            r_ref_count  <= '0;
            r_test_count <= '0;
            r_cap        <= 1'b0;
            r_pv         <= 1'b0;
            r_overflow   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ref_count  <= n_ref_count;
            r_test_count <= n_test_count;
            r_cap        <= n_cap;
            r_pv         <= n_pv;
            r_overflow   <= n_overflow;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t          <= n_t;
        r_e          <= n_e;
        r_k          <= n_k;
        r_pref       <= n_pref;
        r_pskip      <= n_pskip;
        r_cur_lo     <= n_cur_lo;
        r_cur_hi     <= n_cur_hi;
        r_shift      <= n_shift;
        r_fail_code  <= n_fail_code;
        r_out_run    <= n_out_run;
        r_out_offset <= n_out_offset;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_run_index = r_out_run;
    assign o_offset    = r_out_offset;
    assign o_status    = r_out_status;
    assign o_last      = r_out_last;

`ifndef SYNTHESIS
    // The fill counts never run past the store depths.
    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ref_count <= RCW'(ioa_pkg::MAX_REF_RANGES)) &&
        (r_test_count <= TCW'(ioa_pkg::MAX_TEST_RANGES)))
        else $error("range count past store depth");

    // While a range is being placed, its index lies below the test count.
    a_place_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ioa_pkg::S_CHECK || r_state == ioa_pkg::S_SCAN ||
         r_state == ioa_pkg::S_WRITE) |-> (r_t < r_test_count))
        else $error("placement index outside the loaded test ranges");

    // A failure result is always a lone, final result with zero index and offset.
    a_fail_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ioa_pkg::ST_OK) |->
        (o_last && o_run_index == '0 && o_offset == '0))
        else $error("malformed failure result");

    // A solve result only appears once the sequencer has left the placement loop.
    a_emit_after_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && n_out_valid) |->
        (r_state == ioa_pkg::S_E_WAIT || r_state == ioa_pkg::S_FAIL))
        else $error("result loaded outside the emit states");
`endif

endmodule

>>> bench/tb_interval_offset_allocator.sv
`timescale 1ns / 1ps
// Self-checking testbench for interval_offset_allocator: directed table, then random phases.
// Depends on ioa_pkg and the allocator RTL; needs no files or arguments.

module tb_interval_offset_allocator;

    localparam int          BATCH_W         = ioa_pkg::BATCH_W;
    localparam int          KIND_W          = ioa_pkg::KIND_W;
    localparam int          RUN_W           = ioa_pkg::RUN_W;
    localparam int          STATUS_W        = ioa_pkg::STATUS_W;
    localparam int          CFG_IDX_W       = ioa_pkg::CFG_IDX_W;
    localparam int          MAX_REF_RANGES  = ioa_pkg::MAX_REF_RANGES;
    localparam int          MAX_TEST_RANGES = ioa_pkg::MAX_TEST_RANGES;

    localparam int          SETTLE_CYCLES = 40;
    localparam int          CYCLE_LIMIT   = 4000000;
    localparam int          HOLD_CYCLES   = 1500;
    localparam int          REPORT_MAX    = 10;
    localparam logic [BATCH_W-1:0] TOP_BATCH = BATCH_W'(9999999);
    // The fourth kind code has no meaning; the block must ignore it.
    localparam logic [KIND_W-1:0]  KIND_SPARE = 2'd3;

    // One result beat as the block should deliver it.
    typedef struct packed {
        logic [RUN_W-1:0]   run_index;
        logic [BATCH_W-1:0] offset;
        ioa_pkg::t_status   status;
        logic               last;
    } t_placement;

    // One row of the directed table. Where typed is set the single result of a solve
    // is written in here; otherwise the predictor supplies it.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [BATCH_W-1:0] first;
        logic [BATCH_W-1:0] last;
        logic               typed;
        logic [RUN_W-1:0]   run_index;
        logic [BATCH_W-1:0] offset;
        ioa_pkg::t_status   status;
    } t_plan_row;

    localparam int PLAN_LEN = 16;

    t_plan_row plan [PLAN_LEN] = '{
        // A solve straight after reset has nothing loaded.
        '{ioa_pkg::KIND_SOLVE, 24'd0, 24'd0, 1'b1, 4'd0, 24'd0, ioa_pkg::ST_EMPTY},
        // A lone test range fits at offset zero.
        '{ioa_pkg::KIND_TEST, 24'd0, 24'd0, 1'b0, 4'd0, 24'd0, ioa_pkg::ST_OK},
        '{ioa_pkg::KIND_SOLVE, 24'd0, 24'd0, 1'b1, 4'd0, 24'd0, ioa_pkg::ST_OK},
        // A reference covering every batch leaves no room below the limit.
        '{ioa_pkg::KIND_REF, 24'd0, TOP_BATCH, 1'b0, 4'd0, 24'd0, ioa_pkg::ST_OK},
        '{ioa_pkg::KIND_TEST, 24'd5, 24'd5, 1'b0, 4'd0, 24'd0, ioa_pkg::ST_OK},
        '{ioa_pkg::KIND_SOLVE, 24'd0, 24'd0, 1'b1, 4'd0, 24'd0, ioa_pkg::ST_LIMIT},
        // Mixed set: an inverted reference, top batch, an inverted test range
        // and an ignored beat in the middle.
        '{ioa_pkg::KIND_REF, 24'd1000, 24'd1999, 1'b0, 4'd0, 24'd0, ioa_pkg::ST_OK},
        '{ioa_pkg::KIND_REF, 24'd5000, 24'd4000, 1'b0, 4'd0, 24'd0, ioa_pkg::ST_OK},
        '{ioa_pkg::KIND_TEST, 24'd500, 24'd1500, 1'b0, 4'd0, 24'd0, ioa_pkg::ST_OK},
        '{ioa_pkg::KIND_TEST, TOP_BATCH, TOP_BATCH, 1'b0, 4'd0, 24'd0, ioa_pkg::ST_OK},
        '{ioa_pkg::KIND_TEST, 24'd3000, 24'd1000, 1'b0, 4'd0, 24'd0, ioa_pkg::ST_OK},
        '{KIND_SPARE, 24'd123, 24'd456, 1'b0, 4'd0, 24'd0, ioa_pkg::ST_OK},
        '{ioa_pkg::KIND_SOLVE, TOP_BATCH, 24'd0, 1'b0, 4'd0, 24'd0, ioa_pkg::ST_OK},
        // Test ranges with no reference at all must still push each other apart.
        '{ioa_pkg::KIND_TEST, 24'd10, 24'd20, 1'b0, 4'd0, 24'd0, ioa_pkg::ST_OK},
        '{ioa_pkg::KIND_TEST, 24'd15, 24'd25, 1'b0, 4'd0, 24'd0, ioa_pkg::ST_OK},
        '{ioa_pkg::KIND_SOLVE, 24'd0, TOP_BATCH, 1'b0, 4'd0, 24'd0, ioa_pkg::ST_OK}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [KIND_W-1:0]    i_kind = ioa_pkg::KIND_REF;
    logic [BATCH_W-1:0]   i_first_batch = '0;
    logic [BATCH_W-1:0]   i_last_batch = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [RUN_W-1:0]     o_run_index;
    logic [BATCH_W-1:0]   o_offset;
    logic [STATUS_W-1:0]  o_status;
    logic                 o_last;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = ioa_pkg::CFG_OFFSET_STEP;
    logic [BATCH_W-1:0]   i_cfg_data = '0;

    // Predictor state: its own copy of the registers and the range stores.
    logic [BATCH_W-1:0] stride_cfg  = ioa_pkg::STEP_RESET;
    logic [BATCH_W-1:0] ceiling_cfg = ioa_pkg::MAX_BATCH_RESET;
    logic [BATCH_W-1:0] fence_lo [MAX_REF_RANGES];
    logic [BATCH_W-1:0] fence_hi [MAX_REF_RANGES];
    logic [BATCH_W-1:0] run_lo [MAX_TEST_RANGES];
    logic [BATCH_W-1:0] run_hi [MAX_TEST_RANGES];
    longint             run_shift [MAX_TEST_RANGES];
    int                 fence_cnt = 0;
    int                 run_cnt = 0;
    bit                 spilled = 1'b0;

    // Offsets still owed by the block, oldest first.
    t_placement offsets_due [$];

    // Traffic shaping, shared between the stimulus and the receiver.
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        hold_go = 1'b0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned gen_base = 0;
    int unsigned gen_win = 0;
    int unsigned gen_wmax = 0;
    bit          gen_wide = 1'b0;

    int mismatches = 0;
    int results_checked = 0;
    int beats_moved = 0;
    int beats_ignored = 0;
    int solves = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    int cycle_count = 0;

    interval_offset_allocator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_first_batch (i_first_batch),
        .i_last_batch  (i_last_batch),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_run_index   (o_run_index),
        .o_offset      (o_offset),
        .o_status      (o_status),
        .o_last        (o_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Inclusive overlap, tested from both sides. An inverted range contains no point,
    // but its endpoints can still fall inside the other range.
    function automatic bit spans_clash(input longint alo, input longint ahi,
                                       input longint blo, input longint bhi);
        return (blo >= alo && blo <= ahi) || (bhi >= alo && bhi <= ahi) ||
               (alo >= blo && alo <= bhi) || (ahi >= blo && ahi <= bhi);
    endfunction

    // Updates the predictor with one accepted beat and returns the results it causes.
    function automatic void predict_offsets(input logic [KIND_W-1:0] kind,
                                            input logic [BATCH_W-1:0] first,
                                            input logic [BATCH_W-1:0] last,
                                            output t_placement fresh [$]);
        longint stride;
        longint limit;
        longint lo;
        longint hi;
        bit     found;
        bit     overrun;
        fresh = {};
        case (kind)
            ioa_pkg::KIND_REF: begin
                if (fence_cnt < MAX_REF_RANGES) begin
                    fence_lo[fence_cnt] = first;
                    fence_hi[fence_cnt] = last;
                    fence_cnt++;
                end else begin
                    spilled = 1'b1;
                end
            end
            ioa_pkg::KIND_TEST: begin
                if (run_cnt < MAX_TEST_RANGES) begin
                    run_lo[run_cnt] = first;
                    run_hi[run_cnt] = last;
                    run_shift[run_cnt] = 0;
                    run_cnt++;
                end else begin
                    spilled = 1'b1;
                end
            end
            ioa_pkg::KIND_SOLVE: begin
                // A zero step behaves as one; the limit may be negative.
                stride = (stride_cfg == 0) ? 1 : longint'(stride_cfg);
                limit = longint'(ceiling_cfg) - 2 * stride;
                overrun = 1'b0;
                if (spilled) begin
                    fresh.insert(fresh.size(), t_placement'{RUN_W'(0), BATCH_W'(0),
                                                            ioa_pkg::ST_CAPACITY, 1'b1});
                end else if (run_cnt == 0) begin
                    fresh.insert(fresh.size(), t_placement'{RUN_W'(0), BATCH_W'(0),
                                                            ioa_pkg::ST_EMPTY, 1'b1});
                end else begin
                    // Ranges are placed in load order; later ones see earlier ones at
                    // their chosen offsets and earlier failures at their last try.
                    for (int t = 0; t < run_cnt; t++) begin
                        found = 1'b0;
                        while (!found && run_shift[t] <= limit) begin
                            lo = longint'(run_lo[t]) + run_shift[t];
                            hi = longint'(run_hi[t]) + run_shift[t];
                            found = 1'b1;
                            for (int i = 0; i < fence_cnt; i++)
                                if (spans_clash(fence_lo[i], fence_hi[i], lo, hi))
                                    found = 1'b0;
                            for (int i = 0; i < run_cnt; i++)
                                if (i != t && spans_clash(longint'(run_lo[i]) + run_shift[i],
                                                          longint'(run_hi[i]) + run_shift[i],
                                                          lo, hi))
                                    found = 1'b0;
                            if (!found)
                                run_shift[t] += stride;
                        end
                        if (!found)
                            overrun = 1'b1;
                    end
                    if (overrun) begin
                        fresh.insert(fresh.size(), t_placement'{RUN_W'(0), BATCH_W'(0),
                                                                ioa_pkg::ST_LIMIT, 1'b1});
                    end else begin
                        for (int t = 0; t < run_cnt; t++)
                            fresh.insert(fresh.size(),
                                         t_placement'{RUN_W'(t), run_shift[t][BATCH_W-1:0],
                                                      ioa_pkg::ST_OK, t == run_cnt - 1});
                    end
                end
                fence_cnt = 0;
                run_cnt = 0;
                spilled = 1'b0;
                solves++;
            end
            default: ;
        endcase
    endfunction

    // Presents one input beat after a random gap and holds it until the block takes it.
    // Valid is only lowered inside the gap, so a back-to-back beat never sees two
    // assignments to valid in one time step.
    task automatic offer_beat(input logic [KIND_W-1:0] kind, input logic [BATCH_W-1:0] first,
                              input logic [BATCH_W-1:0] last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_first_batch <= first;
        i_last_batch  <= last;
        do @(posedge i_clk); while (!o_in_ready);
        beats_moved++;
        if (kind == KIND_SPARE)
            beats_ignored++;
    endtask

    // Draws a range around the current base, offers it and records what it should cause.
    // Narrow ranges keep the number of offset tries per solve small; fully random ranges
    // are only drawn when the offset limit is a few hundred steps away at most.
    task automatic send_and_predict(input logic [KIND_W-1:0] kind);
        t_placement         fresh [$];
        longint             lo;
        longint             hi;
        logic [BATCH_W-1:0] first;
        logic [BATCH_W-1:0] last;
        if (gen_wide && $urandom_range(0, 9) == 0) begin
            first = BATCH_W'($urandom_range(0, TOP_BATCH));
            last  = BATCH_W'($urandom_range(0, TOP_BATCH));
        end else begin
            lo = longint'(gen_base) + $urandom_range(0, gen_win);
            hi = lo + $urandom_range(0, gen_wmax);
            if (lo > TOP_BATCH)
                lo = TOP_BATCH;
            if (hi > TOP_BATCH)
                hi = TOP_BATCH;
            if ($urandom_range(0, 11) == 0) begin
                first = BATCH_W'(hi);
                last  = BATCH_W'(lo);
            end else begin
                first = BATCH_W'(lo);
                last  = BATCH_W'(hi);
            end
        end
        offer_beat(kind, first, last);
        predict_offsets(kind, first, last, fresh);
        foreach (fresh[k])
            offsets_due.insert(offsets_due.size(), fresh[k]);
    endtask

    function automatic int pick_count();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom_range(1, 4);
        else if (r < 9)
            return $urandom_range(5, 10);
        return MAX_TEST_RANGES;
    endfunction

    // Lets every owed result arrive, then gives the block time to go idle.
    task automatic drain_and_settle();
        while (offsets_due.size() != 0) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One random phase: reprogram both registers while idle, then stream sequences of
    // loads closed by a solve, with some overfilled stores and some plain noise.
    task automatic run_phase(input logic [BATCH_W-1:0] stride, input logic [BATCH_W-1:0] ceiling,
                             input int send_pct, input int recv_pct, input int beats,
                             input bit hold);
        longint           unit;
        longint           limit;
        int               sent;
        int               r;
        int               n_fence;
        int               n_run;
        logic [KIND_W-1:0] kind;
        drain_and_settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= ioa_pkg::CFG_OFFSET_STEP;
        i_cfg_data  <= stride;
        @(posedge i_clk);
        i_cfg_index <= ioa_pkg::CFG_MAX_BATCH;
        i_cfg_data  <= ceiling;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        stride_cfg  = stride;
        ceiling_cfg = ceiling;

        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
        if (hold)
            hold_go <= 1'b1;
        unit = (stride == 0) ? 1 : longint'(stride);
        limit = longint'(ceiling) - 2 * unit;
        gen_wmax = (2 * unit > TOP_BATCH) ? TOP_BATCH : int'(2 * unit);
        gen_win = (12 * unit > TOP_BATCH) ? TOP_BATCH : int'(12 * unit);
        gen_wide = (limit < 0) || (limit / unit <= 300);

        sent = 0;
        while (sent < beats) begin
            gen_base = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, TOP_BATCH);
            r = $urandom_range(0, 99);
            if (r < 78) begin
                n_fence = ($urandom_range(0, 4) == 0) ? 0 : pick_count();
                n_run = ($urandom_range(0, 9) == 0) ? 0 : pick_count();
                while (n_fence + n_run > 0) begin
                    if (n_run == 0 || (n_fence != 0 && $urandom_range(0, 1) == 1)) begin
                        kind = ioa_pkg::KIND_REF;
                        n_fence--;
                    end else begin
                        kind = ioa_pkg::KIND_TEST;
                        n_run--;
                    end
                    send_and_predict(kind);
                    sent++;
                end
                send_and_predict(ioa_pkg::KIND_SOLVE);
                sent++;
            end else if (r < 88) begin
                // Overfill one store so that the solve must report lost ranges.
                kind = ($urandom_range(0, 1) == 1) ? ioa_pkg::KIND_REF : ioa_pkg::KIND_TEST;
                repeat ($urandom_range(MAX_TEST_RANGES + 1, MAX_TEST_RANGES + 3)) begin
                    send_and_predict(kind);
                    sent++;
                end
                send_and_predict(ioa_pkg::KIND_SOLVE);
                sent++;
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    kind = KIND_W'($urandom_range(ioa_pkg::KIND_REF, KIND_SPARE));
                    send_and_predict(kind);
                    if (kind != KIND_SPARE)
                        sent++;
                end
            end
            // Now and then the sender waits for every owed result before going on.
            if ($urandom_range(0, 9) == 0) begin
                while (offsets_due.size() != 0) begin
                    i_in_valid <= 1'b0;
                    @(posedge i_clk);
                end
            end
        end
        // Close the phase with a solve so no loaded ranges carry over.
        send_and_predict(ioa_pkg::KIND_SOLVE);
    endtask

    // Receiver: checks each result beat against the oldest owed offset, then decides
    // whether to take the next one. A requested hold-off is counted down here.
    always @(posedge i_clk) begin
        t_placement due;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (offsets_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result beat: run %0d offset %0d status %0d last %0d",
                             o_run_index, o_offset, o_status, o_last);
            end else begin
                due = offsets_due.pop_front();
                results_checked++;
                status_seen[due.status]++;
                if (o_run_index !== due.run_index || o_offset !== due.offset ||
                    o_status !== due.status || o_last !== due.last) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"result %0d mismatch: expected run %0d offset %0d status %0d",
                                  " last %0d, got run %0d offset %0d status %0d last %0d"},
                                 results_checked, due.run_index, due.offset, due.status,
                                 due.last, o_run_index, o_offset, o_status, o_last);
                end
            end
        end
        if (hold_go && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still owed",
                 cycle_count, offsets_due.size());
        $display("[interval_offset_allocator] ERROR");
        $finish;
    end

    initial begin
        t_placement fresh [$];
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table on the reset settings.
        for (int r = 0; r < PLAN_LEN; r++) begin
            offer_beat(plan[r].kind, plan[r].first, plan[r].last);
            predict_offsets(plan[r].kind, plan[r].first, plan[r].last, fresh);
            if (plan[r].typed) begin
                offsets_due.insert(offsets_due.size(),
                                   t_placement'{plan[r].run_index, plan[r].offset,
                                                plan[r].status, 1'b1});
            end else begin
                foreach (fresh[k])
                    offsets_due.insert(offsets_due.size(), fresh[k]);
            end
        end

        // Random phases: step, max batch, sender idle %, receiver stall %, beats, hold-off.
        run_phase(24'd1000, TOP_BATCH, 0, 0, 110, 1'b0);
        run_phase(24'd1, TOP_BATCH, 77, 0, 50, 1'b0);
        run_phase(TOP_BATCH, 24'd0, 0, 77, 25, 1'b0);
        run_phase(24'd37, 24'd1500, 10, 10, 80, 1'b0);
        run_phase(24'd0, 24'd40, 0, 77, 40, 1'b0);
        run_phase(24'd5000, 24'd200000, 0, 0, 70, 1'b1);

        drain_and_settle();
        $display("Run moved %0d input beats (%0d ignored) through %0d solves; %0d results checked.",
                 beats_moved, beats_ignored, solves, results_checked);
        $display("Results by status: valid %0d, empty %0d, limit %0d, capacity %0d; %0d mismatches.",
                 status_seen[ioa_pkg::ST_OK], status_seen[ioa_pkg::ST_EMPTY],
                 status_seen[ioa_pkg::ST_LIMIT], status_seen[ioa_pkg::ST_CAPACITY], mismatches);
        if (mismatches == 0) begin
            $display("[interval_offset_allocator] OK");
        end else begin
            $display("[interval_offset_allocator] ERROR");
        end
        $finish;
    end

endmodule
